// ===== rtl/core/mcped_pkg.sv =====
package mcped_pkg;

    localparam int NOW_W  = 32;
    localparam int CH_W   = 3;
    localparam int CODE_W = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [1:0] PH_IDLE      = 2'd0;
    localparam logic [1:0] PH_DEBOUNCE  = 2'd1;
    localparam logic [1:0] PH_ACTIVE    = 2'd2;
    localparam logic [1:0] PH_LONG_WAIT = 2'd3;

    localparam logic [CODE_W-1:0] EV_NONE    = 3'd0;
    localparam logic [CODE_W-1:0] EV_TRIGGER = 3'd1;
    localparam logic [CODE_W-1:0] EV_RELEASE = 3'd2;
    localparam logic [CODE_W-1:0] EV_LONG    = 3'd3;
    localparam logic [CODE_W-1:0] EV_REPEAT  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LIMIT_MS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_LIMIT_MS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_PERIOD_MS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW_MASK = 3'd4;

    typedef struct packed {
        logic [7:0]  debounce_count;
        logic [15:0] short_limit_ms;
        logic [15:0] long_limit_ms;
        logic [6:0]  scan_period_ms;
        logic [7:0]  active_low_mask;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        debounce_count:  8'd3,
        short_limit_ms:  16'd500,
        long_limit_ms:   16'd1000,
        scan_period_ms:  7'd20,
        active_low_mask: 8'd96
    };

    typedef struct packed {
        logic [CH_W-1:0]  channel;
        logic             raw_level;
        logic [NOW_W-1:0] now_ms;
    } scan_t;

endpackage

// ===== rtl/core/mcped_scan_if.sv =====
interface mcped_scan_if;
    import mcped_pkg::*;

    logic              valid;
    logic              ready;
    logic [CH_W-1:0]   channel;
    logic              raw_level;
    logic [NOW_W-1:0]  now_ms;

    modport source (output valid, output channel, output raw_level, output now_ms,
                    input ready);
    modport sink   (input valid, input channel, input raw_level, input now_ms,
                    output ready);
endinterface

// ===== rtl/core/mcped_report_if.sv =====
interface mcped_report_if;
    import mcped_pkg::*;

    logic               valid;
    logic               ready;
    logic [CH_W-1:0]    event_channel;
    logic [CODE_W-1:0]  event_code;
    logic               held;

    modport source (output valid, output event_channel, output event_code, output held,
                    input ready);
    modport sink   (input valid, input event_channel, input event_code, input held,
                     output ready);
endinterface

// ===== rtl/core/mcped_ram.sv =====
module mcped_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/mcped_cfg.sv =====
module mcped_cfg
    import mcped_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_DEBOUNCE_COUNT:  cfg_next.debounce_count  = wr_data[7:0];
                CFG_SHORT_LIMIT_MS:  cfg_next.short_limit_ms  = wr_data;
                CFG_LONG_LIMIT_MS:   cfg_next.long_limit_ms   = wr_data;
                CFG_SCAN_PERIOD_MS:  cfg_next.scan_period_ms  = wr_data[6:0];
                CFG_ACTIVE_LOW_MASK: cfg_next.active_low_mask = wr_data[7:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/mcped_mod.sv =====
module mcped_mod
    import mcped_pkg::*;
#(
    parameter int REPEAT_PERIOD_MS = 100,
    localparam int RW = (REPEAT_PERIOD_MS > 1) ? $clog2(REPEAT_PERIOD_MS) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  logic          in_valid,
    input  scan_t         in_item,
    output logic          out_valid,
    output scan_t         out_item,
    output logic [RW-1:0] out_rem
);

    localparam int STAGES = 8;
    localparam int BITS   = NOW_W / STAGES;
    localparam logic [RW:0] PMOD = (RW + 1)'(REPEAT_PERIOD_MS);

    logic          valid_reg [STAGES];
    scan_t         item_reg  [STAGES];
    logic [RW-1:0] rem_reg   [STAGES];

    function automatic logic [RW-1:0] fold(input logic [RW-1:0] r,
                                           input logic [BITS-1:0] nib);
        logic [RW:0] t;
        int          i;
        t = {1'b0, r};
        for (i = 0; i < BITS; i++)
        begin
            t = {t[RW-1:0], nib[BITS-1-i]};
            if (t >= PMOD)
            begin
                t = t - PMOD;
            end
        end
        return t[RW-1:0];
    endfunction

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic          valid_src;
        scan_t         item_src;
        logic [RW-1:0] rem_src;

        if (s == 0)
        begin : g_first
            assign valid_src = in_valid;
            assign item_src  = in_item;
            assign rem_src   = '0;
        end
        else
        begin : g_rest
            assign valid_src = valid_reg[s-1];
            assign item_src  = item_reg[s-1];
            assign rem_src   = rem_reg[s-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (advance)
            begin
                valid_reg[s] <= valid_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                item_reg[s] <= item_src;
                rem_reg[s]  <= fold(rem_src, item_src.now_ms[NOW_W-1-BITS*s -: BITS]);
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_item  = item_reg[STAGES-1];
    assign out_rem   = rem_reg[STAGES-1];

endmodule

// ===== rtl/core/multi_channel_press_event_detector_unit.sv =====
// Channel  Side    Fields                                   Width
// scan     sink    channel, raw_level, now_ms               3 / 1 / 32
// report   source  event_channel, event_code, held          3 / 3 / 1
// wr_*     write   wr_en, wr_index, wr_data                 1 / 3 / 16
//
// One item per cycle unless a stall holds the pipeline. Once an item is
// taken, 8 stages fold now_ms into now_ms mod REPEAT_PERIOD_MS, the channel
// state RAM is read, then the state is updated and output register loaded.
// Reset clears per-channel valid bits, so every channel starts idle at once.
// While a result waits on report.ready the whole pipeline holds.
module multi_channel_press_event_detector_unit
    import mcped_pkg::*;
#(
    parameter int CHANNELS         = 8,
    parameter int REPEAT_PERIOD_MS = 100
) (
    input  logic                  clk,
    input  logic                  rst_n,
    mcped_scan_if.sink            scan,
    mcped_report_if.source        report,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data
);

    localparam int DEPTH = (CHANNELS < 8) ? CHANNELS : 8;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW    = (REPEAT_PERIOD_MS > 1) ? $clog2(REPEAT_PERIOD_MS) : 1;
    localparam logic [RW:0] PMOD = (RW + 1)'(REPEAT_PERIOD_MS);
    localparam logic [RW:0] KMOD = (RW + 1)'((64'd1 << 32) % REPEAT_PERIOD_MS);
    localparam logic [6:0]  CH_LIMIT = 7'(CHANNELS);

    typedef struct packed {
        logic [1:0]       phase;
        logic [7:0]       count;
        logic [NOW_W-1:0] start;
        logic [RW-1:0]    start_rem;
        logic             long_sent;
        logic             trig_sent;
    } entry_t;

    cfg_t cfg;

    mcped_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    logic          advance;
    scan_t         in_item;
    logic          m_valid;
    scan_t         m_item;
    logic [RW-1:0] m_rem;

    assign in_item = '{channel: scan.channel, raw_level: scan.raw_level, now_ms: scan.now_ms};

    mcped_mod #(
        .REPEAT_PERIOD_MS (REPEAT_PERIOD_MS)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (scan.valid),
        .in_item   (in_item),
        .out_valid (m_valid),
        .out_item  (m_item),
        .out_rem   (m_rem)
    );

    logic [AW-1:0] rd_addr;
    logic          wr_ent_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_ent;
    entry_t        rd_ent;

    assign rd_addr = ({4'd0, m_item.channel} < CH_LIMIT) ? m_item.channel[AW-1:0] : '0;

    mcped_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (wr_ent_en),
        .waddr (wr_addr),
        .wdata (wr_ent),
        .re    (advance),
        .raddr (rd_addr),
        .rdata (rd_ent)
    );

    logic [DEPTH-1:0] ent_valid_reg;
    logic [DEPTH-1:0] ent_valid_next;

    logic          c_valid_reg;
    scan_t         c_item_reg;
    logic [RW-1:0] c_rem_reg;
    logic          c_hit_reg;
    entry_t        c_fwd_reg;
    logic          c_vld_reg;

    logic            out_valid_reg;
    logic [CH_W-1:0] out_channel_reg;
    logic [CODE_W-1:0] out_code_reg;
    logic            out_held_reg;

    entry_t            st;
    entry_t            nxt;
    logic [CODE_W-1:0] ev;
    logic              held;
    logic              in_range;
    logic              act;
    logic [NOW_W-1:0]  dlt;
    logic              borrow;
    logic [RW:0]       rdiff;
    logic [RW:0]       m1;
    logic [RW:0]       m2;
    logic              rep_win;
    logic [7:0]        cnt_inc;

    assign advance    = !(out_valid_reg && !report.ready);
    assign scan.ready = advance;

    always_comb
    begin
        in_range = ({4'd0, c_item_reg.channel} < CH_LIMIT);
        st       = c_hit_reg ? c_fwd_reg : (c_vld_reg ? rd_ent : '0);
        nxt      = st;
        ev       = EV_NONE;
        act      = c_item_reg.raw_level ^ cfg.active_low_mask[c_item_reg.channel];
        dlt      = c_item_reg.now_ms - st.start;
        borrow   = (c_item_reg.now_ms < st.start);
        rdiff    = {1'b0, c_rem_reg} - {1'b0, st.start_rem};
        m1       = rdiff[RW] ? (rdiff + PMOD) : rdiff;
        m2       = {1'b0, m1[RW-1:0]} + (borrow ? KMOD : '0);
        if (m2 >= PMOD)
        begin
            m2 = m2 - PMOD;
        end
        rep_win  = (32'(m2[RW-1:0]) < 32'(cfg.scan_period_ms));
        cnt_inc  = (st.count != 8'hFF) ? (st.count + 8'd1) : st.count;

        unique case (st.phase)
            PH_IDLE:
            begin
                if (act)
                begin
                    nxt.phase = PH_DEBOUNCE;
                    nxt.count = 8'd0;
                end
            end
            PH_DEBOUNCE:
            begin
                if (act)
                begin
                    nxt.count = cnt_inc;
                    if (cnt_inc >= cfg.debounce_count)
                    begin
                        nxt.phase     = PH_ACTIVE;
                        nxt.start     = c_item_reg.now_ms;
                        nxt.start_rem = c_rem_reg;
                        nxt.long_sent = 1'b0;
                        nxt.trig_sent = 1'b0;
                    end
                end
                else
                begin
                    nxt.phase = PH_IDLE;
                end
            end
            PH_ACTIVE:
            begin
                if (!act)
                begin
                    if (dlt <= {16'd0, cfg.short_limit_ms})
                    begin
                        ev = EV_RELEASE;
                    end
                    nxt.phase = PH_IDLE;
                end
                else
                begin
                    if (dlt > {16'd0, cfg.short_limit_ms})
                    begin
                        nxt.phase = PH_LONG_WAIT;
                    end
                    if (!st.trig_sent)
                    begin
                        nxt.trig_sent = 1'b1;
                        ev            = EV_TRIGGER;
                    end
                end
            end
            PH_LONG_WAIT:
            begin
                if (!act)
                begin
                    ev        = EV_RELEASE;
                    nxt.phase = PH_IDLE;
                end
                else if (dlt >= {16'd0, cfg.long_limit_ms})
                begin
                    if (!st.long_sent)
                    begin
                        nxt.long_sent = 1'b1;
                        ev            = EV_LONG;
                    end
                    else if (rep_win)
                    begin
                        ev = EV_REPEAT;
                    end
                end
            end
            default:
            begin
                nxt = st;
            end
        endcase

        held = (nxt.phase == PH_ACTIVE) || (nxt.phase == PH_LONG_WAIT);
        if (!in_range)
        begin
            ev   = EV_NONE;
            held = 1'b0;
        end
    end

    assign wr_ent_en = advance && c_valid_reg && in_range;
    assign wr_addr   = c_item_reg.channel[AW-1:0];
    assign wr_ent    = nxt;

    always_comb
    begin
        ent_valid_next = ent_valid_reg;
        if (wr_ent_en)
        begin
            ent_valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_valid_reg <= '0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ent_valid_reg <= ent_valid_next;
            if (advance)
            begin
                c_valid_reg   <= m_valid;
                out_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            c_item_reg      <= m_item;
            c_rem_reg       <= m_rem;
            c_hit_reg       <= wr_ent_en && (wr_addr == rd_addr);
            c_fwd_reg       <= wr_ent;
            c_vld_reg       <= ent_valid_reg[rd_addr];
            out_channel_reg <= c_item_reg.channel;
            out_code_reg    <= ev;
            out_held_reg    <= held;
        end
    end

    assign report.valid         = out_valid_reg;
    assign report.event_channel = out_channel_reg;
    assign report.event_code    = out_code_reg;
    assign report.held          = out_held_reg;

endmodule

// ===== rtl/core/mcped_chk.sv =====
module mcped_chk
    import mcped_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              scan_ready,
    input logic              rep_valid,
    input logic              rep_ready,
    input logic [CH_W-1:0]   rep_channel,
    input logic [CODE_W-1:0] rep_code,
    input logic              rep_held
);

    a_rep_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rep_valid && !rep_ready |=> rep_valid && $stable(rep_channel)
            && $stable(rep_code) && $stable(rep_held))
        else $error("report item changed while stalled");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        rep_valid && !rep_ready |-> !scan_ready)
        else $error("scan taken while report stalled");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        rep_valid |-> rep_code <= EV_REPEAT)
        else $error("event code out of range");

    a_release: assert property (@(posedge clk) disable iff (!rst_n)
        rep_valid && rep_code == EV_RELEASE |-> !rep_held)
        else $error("release reported with channel held");

    a_held: assert property (@(posedge clk) disable iff (!rst_n)
        rep_valid && (rep_code == EV_TRIGGER || rep_code == EV_LONG
            || rep_code == EV_REPEAT) |-> rep_held)
        else $error("press event reported with channel not held");

endmodule

bind multi_channel_press_event_detector_unit mcped_chk u_mcped_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .scan_ready  (scan.ready),
    .rep_valid   (report.valid),
    .rep_ready   (report.ready),
    .rep_channel (report.event_channel),
    .rep_code    (report.event_code),
    .rep_held    (report.held)
);
